@@ hw/rtl/spq_pkg.sv @@
package spq_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int DATA_W = 32;
  localparam int OCC_W = 5;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef logic signed [DATA_W-1:0] data_t;

  typedef struct packed {
    logic  enq;
    logic  deq;
    data_t new_val;
    data_t new_pri;
  } cell_ctrl_t;

endpackage

@@ hw/rtl/spq_req_if.sv @@
interface spq_req_if;
  logic            valid;
  logic            ready;
  spq_pkg::op_t    operation;
  spq_pkg::data_t  item_value;
  spq_pkg::data_t  item_priority;

  modport source (output valid, operation, item_value, item_priority, input ready);
  modport sink (input valid, operation, item_value, item_priority, output ready);
endinterface

@@ hw/rtl/spq_rsp_if.sv @@
interface spq_rsp_if;
  logic                        valid;
  logic                        ready;
  spq_pkg::status_t            status;
  spq_pkg::data_t              removed_value;
  spq_pkg::data_t              removed_priority;
  logic [spq_pkg::OCC_W-1:0]   occupancy;
  spq_pkg::data_t              top_value;
  spq_pkg::data_t              top_priority;

  modport source (
    output valid, status, removed_value, removed_priority, occupancy, top_value,
      top_priority,
    input ready
  );
  modport sink (
    input valid, status, removed_value, removed_priority, occupancy, top_value,
      top_priority,
    output ready
  );
endinterface

@@ hw/rtl/sorted_priority_queue_unit.sv @@
// Bounded priority queue built as a row of compare-and-shift cells, head in
// cell 0. Every cell compares its stored priority with the incoming one in
// parallel, so an enqueue or a dequeue is applied to the whole row at once and the block
// takes one transaction per cycle; the result sits in an output register and
// req.ready is high whenever that register is empty or being taken in the same
// cycle. Equal priorities leave in arrival order. An enqueue when full and a
// dequeue when empty leave the queue unchanged and are flagged in status.
// Slots carry no reset; occupancy alone marks which cells hold pairs.
module sorted_priority_queue_unit #(
  parameter int CAPACITY = spq_pkg::CAPACITY_DEFAULT
) (
  input logic      clk,
  input logic      rst,
  spq_req_if.sink  req,
  spq_rsp_if.source rsp
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  spq_pkg::cell_ctrl_t ctrl;
  logic                accept;
  logic                full;
  logic                empty;

  logic                cell_ge   [CAPACITY];
  spq_pkg::data_t      cell_val  [CAPACITY];
  spq_pkg::data_t      cell_pri  [CAPACITY];
  logic                left_ge   [CAPACITY];
  spq_pkg::data_t      left_val  [CAPACITY];
  spq_pkg::data_t      left_pri  [CAPACITY];
  spq_pkg::data_t      right_val [CAPACITY];
  spq_pkg::data_t      right_pri [CAPACITY];

  logic                    out_valid;
  spq_pkg::status_t        out_status;
  spq_pkg::data_t          out_rem_val;
  spq_pkg::data_t          out_rem_pri;
  logic [spq_pkg::OCC_W-1:0] out_occ;
  spq_pkg::data_t          out_top_val;
  spq_pkg::data_t          out_top_pri;

  spq_pkg::status_t        status_next;
  spq_pkg::data_t          rem_val_next;
  spq_pkg::data_t          rem_pri_next;
  spq_pkg::data_t          top_val_next;
  spq_pkg::data_t          top_pri_next;

  assign req.ready = !out_valid || rsp.ready;
  assign accept = req.valid && req.ready;
  assign full = count == CNT_W'(CAPACITY);
  assign empty = count == '0;

  always_comb begin
    ctrl.enq = accept && (req.operation == spq_pkg::OP_ENQUEUE) && !full;
    ctrl.deq = accept && (req.operation == spq_pkg::OP_DEQUEUE) && !empty;
    ctrl.new_val = req.item_value;
    ctrl.new_pri = req.item_priority;
  end

  // neighbor links
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (i == 0) begin
        left_ge[i] = 1'b1;
        left_val[i] = req.item_value;
        left_pri[i] = req.item_priority;
      end else begin
        left_ge[i] = cell_ge[i-1];
        left_val[i] = cell_val[i-1];
        left_pri[i] = cell_pri[i-1];
      end
      if (i == CAPACITY - 1) begin
        right_val[i] = cell_val[i];
        right_pri[i] = cell_pri[i];
      end else begin
        right_val[i] = cell_val[i+1];
        right_pri[i] = cell_pri[i+1];
      end
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    spq_cell #(
      .IDX   (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .count     (count),
      .left_ge   (left_ge[g]),
      .left_val  (left_val[g]),
      .left_pri  (left_pri[g]),
      .right_val (right_val[g]),
      .right_pri (right_pri[g]),
      .ge        (cell_ge[g]),
      .slot_val  (cell_val[g]),
      .slot_pri  (cell_pri[g])
    );
  end

  always_comb begin
    count_next = count;
    status_next = spq_pkg::ST_DONE;
    rem_val_next = '0;
    rem_pri_next = '0;
    if (req.operation == spq_pkg::OP_ENQUEUE) begin
      if (full) begin
        status_next = spq_pkg::ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (empty) begin
        status_next = spq_pkg::ST_EMPTY;
      end else begin
        count_next = count - CNT_W'(1);
        rem_val_next = cell_val[0];
        rem_pri_next = cell_pri[0];
      end
    end
    if (ctrl.enq) begin
      top_val_next = cell_ge[0] ? cell_val[0] : req.item_value;
      top_pri_next = cell_ge[0] ? cell_pri[0] : req.item_priority;
    end else if (ctrl.deq) begin
      top_val_next = (count > CNT_W'(1)) ? cell_val[1] : '0;
      top_pri_next = (count > CNT_W'(1)) ? cell_pri[1] : '0;
    end else begin
      top_val_next = empty ? '0 : cell_val[0];
      top_pri_next = empty ? '0 : cell_pri[0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      out_valid <= 1'b0;
    end else begin
      if (accept) begin
        count <= count_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_status <= status_next;
      out_rem_val <= rem_val_next;
      out_rem_pri <= rem_pri_next;
      out_occ <= spq_pkg::OCC_W'(count_next);
      out_top_val <= top_val_next;
      out_top_pri <= top_pri_next;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.removed_value = out_rem_val;
  assign rsp.removed_priority = out_rem_pri;
  assign rsp.occupancy = out_occ;
  assign rsp.top_value = out_top_val;
  assign rsp.top_priority = out_top_pri;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("occupancy above capacity");

  a_dequeue_count: assert property (@(posedge clk) disable iff (rst)
    ctrl.deq |=> count == $past(count) - CNT_W'(1))
    else $error("dequeue did not shrink occupancy");

  a_head_order: assert property (@(posedge clk) disable iff (rst)
    count >= CNT_W'(2) |-> cell_pri[0] >= cell_pri[1])
    else $error("head cells out of order");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_status == spq_pkg::ST_FULL) |-> out_occ == spq_pkg::OCC_W'(CAPACITY))
    else $error("full status with wrong occupancy");

endmodule

@@ hw/rtl/spq_cell.sv @@
module spq_cell #(
  parameter int IDX = 0,
  parameter int CNT_W = 5
) (
  input  logic                clk,
  input  spq_pkg::cell_ctrl_t ctrl,
  input  logic [CNT_W-1:0]    count,
  input  logic                left_ge,
  input  spq_pkg::data_t      left_val,
  input  spq_pkg::data_t      left_pri,
  input  spq_pkg::data_t      right_val,
  input  spq_pkg::data_t      right_pri,
  output logic                ge,
  output spq_pkg::data_t      slot_val,
  output spq_pkg::data_t      slot_pri
);

  logic occupied;

  assign occupied = CNT_W'(IDX) < count;
  assign ge = occupied && (slot_pri >= ctrl.new_pri);

  always_ff @(posedge clk) begin
    if (ctrl.enq && !ge) begin
      if (left_ge) begin
        slot_val <= ctrl.new_val;
        slot_pri <= ctrl.new_pri;
      end else begin
        slot_val <= left_val;
        slot_pri <= left_pri;
      end
    end else if (ctrl.deq) begin
      slot_val <= right_val;
      slot_pri <= right_pri;
    end
  end

endmodule
